>>> src/chd_pkg.sv
// shared types, constants and arctangent table for the compass heading pipeline
package chd_pkg;

    // internal vector width: scaled samples stay below 2^57 through every stage
    localparam int VEC_W         = 59;
    localparam int ANGLE_W       = 32;
    localparam int CENTI_W       = 16;
    localparam int PROD_W        = ANGLE_W + CENTI_W;
    localparam int SUM_W         = CENTI_W + 2;
    localparam int SCALE_POINT   = 56;
    localparam int ATAN_ENTRIES  = 24;
    // one stage for pre-rotation, three for conversion and declination
    localparam int PRE_LATENCY   = 1;
    localparam int POST_LATENCY  = 3;

    typedef logic signed [VEC_W-1:0]   vec_t;
    typedef logic [ANGLE_W-1:0]        angle_t;
    typedef logic [CENTI_W-1:0]        centideg_t;
    typedef logic signed [CENTI_W-1:0] decl_t;
    typedef logic [PROD_W-1:0]         prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    localparam centideg_t FULL_CENTIDEG = 16'd36000;
    localparam centideg_t HALF_CENTIDEG = 16'd18000;
    localparam angle_t    HALF_TURN     = 32'h8000_0000;
    localparam prod_t     ROUND_HALF    = 48'h0000_8000_0000;

    // control that travels with each item
    typedef struct packed {
        logic valid;
        logic special;  // y zero: heading fixed, cordic result ignored
        logic half;     // y zero and x negative
    } ctl_t;

    // atan(2^-idx) in units of 2^-32 turn, rounded to nearest
    function automatic angle_t atan_turns(input int unsigned idx);
        angle_t a;
        case (idx)
            0:       a = 32'h2000_0000;
            1:       a = 32'h12E4_051E;
            2:       a = 32'h09FB_385B;
            3:       a = 32'h0511_11D4;
            4:       a = 32'h028B_0D43;
            5:       a = 32'h0145_D7E1;
            6:       a = 32'h00A2_F61E;
            7:       a = 32'h0051_7C55;
            8:       a = 32'h0028_BE53;
            9:       a = 32'h0014_5F2F;
            10:      a = 32'h000A_2F98;
            11:      a = 32'h0005_17CC;
            12:      a = 32'h0002_8BE6;
            13:      a = 32'h0001_45F3;
            14:      a = 32'h0000_A2FA;
            15:      a = 32'h0000_517D;
            16:      a = 32'h0000_28BE;
            17:      a = 32'h0000_145F;
            18:      a = 32'h0000_0A30;
            19:      a = 32'h0000_0518;
            20:      a = 32'h0000_028C;
            21:      a = 32'h0000_0146;
            22:      a = 32'h0000_00A3;
            23:      a = 32'h0000_0051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> src/chd_prerotate.sv
// input stage: sample scaling, half-plane fold and y-zero detection
module chd_prerotate #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS-1:0] mag_x,
    input  logic signed [SAMPLE_BITS-1:0] mag_y,
    output chd_pkg::ctl_t                 ctl_out,
    output chd_pkg::vec_t                 x_out,
    output chd_pkg::vec_t                 y_out,
    output chd_pkg::angle_t               z_out
);
    import chd_pkg::*;

    localparam int SCALE_SH = SCALE_POINT - SAMPLE_BITS;

    ctl_t   ctl_reg, ctl_next;
    vec_t   x_reg, x_next;
    vec_t   y_reg, y_next;
    angle_t z_reg, z_next;
    vec_t   x_sc;
    vec_t   y_sc;
    logic   x_neg;
    logic   y_zero;

    always_comb
    begin
        x_sc   = vec_t'(mag_x) <<< SCALE_SH;
        y_sc   = vec_t'(mag_y) <<< SCALE_SH;
        x_neg  = mag_x[SAMPLE_BITS-1];
        y_zero = (mag_y == '0);

        ctl_next.valid   = in_valid;
        ctl_next.special = y_zero;
        ctl_next.half    = y_zero & x_neg;

        // fold left half plane onto the right by a half turn
        if (x_neg)
        begin
            x_next = -x_sc;
            y_next = -y_sc;
            z_next = HALF_TURN;
        end
        else
        begin
            x_next = x_sc;
            y_next = y_sc;
            z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

>>> src/chd_cordic_stage.sv
// one registered cordic vectoring micro-rotation
module chd_cordic_stage #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  chd_pkg::ctl_t   ctl_in,
    input  chd_pkg::vec_t   x_in,
    input  chd_pkg::vec_t   y_in,
    input  chd_pkg::angle_t z_in,
    output chd_pkg::ctl_t   ctl_out,
    output chd_pkg::vec_t   x_out,
    output chd_pkg::vec_t   y_out,
    output chd_pkg::angle_t z_out
);
    import chd_pkg::*;

    localparam angle_t ATAN = atan_turns(IDX);

    ctl_t   ctl_reg;
    vec_t   x_reg, x_next;
    vec_t   y_reg, y_next;
    angle_t z_reg, z_next;
    vec_t   xs;
    vec_t   ys;

    always_comb
    begin
        // arithmetic shift rounds toward minus infinity
        xs = x_in >>> IDX;
        ys = y_in >>> IDX;
        if (!y_in[VEC_W-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

>>> src/chd_convert.sv
// angle to centidegrees, declination add and single wrap, three stages
module chd_convert (
    input  logic               clk,
    input  logic               rst_n,
    input  chd_pkg::ctl_t      ctl_in,
    input  chd_pkg::angle_t    z_in,
    input  chd_pkg::decl_t     decl,
    output logic               out_valid,
    output chd_pkg::centideg_t heading
);
    import chd_pkg::*;

    // stage a: multiply
    ctl_t      ctl_a_reg;
    prod_t     prod_reg, prod_next;
    // stage b: round and special select
    ctl_t      ctl_b_reg;
    centideg_t base_reg, base_next;
    prod_t     rounded;
    // stage c: declination and wrap
    logic      valid_c_reg;
    centideg_t heading_reg, heading_next;
    sum_t      h_sum;
    sum_t      h_wrap;

    always_comb
    begin
        prod_next = prod_t'(z_in) * prod_t'(FULL_CENTIDEG);
    end

    always_comb
    begin
        rounded = prod_reg + ROUND_HALF;
        if (ctl_a_reg.special)
        begin
            base_next = ctl_a_reg.half ? HALF_CENTIDEG : '0;
        end
        else
        begin
            base_next = rounded[PROD_W-1 -: CENTI_W];
        end
    end

    always_comb
    begin
        h_sum = $signed({2'b00, base_reg}) + sum_t'(decl);
        if (h_sum < 0)
        begin
            h_wrap = h_sum + $signed({2'b00, FULL_CENTIDEG});
        end
        else if (h_sum > $signed({2'b00, FULL_CENTIDEG}))
        begin
            h_wrap = h_sum - $signed({2'b00, FULL_CENTIDEG});
        end
        else
        begin
            h_wrap = h_sum;
        end
        heading_next = h_wrap[CENTI_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg   <= '0;
            ctl_b_reg   <= '0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            ctl_a_reg   <= ctl_in;
            ctl_b_reg   <= ctl_a_reg;
            valid_c_reg <= ctl_b_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        base_reg    <= base_next;
        heading_reg <= heading_next;
    end

    assign out_valid = valid_c_reg;
    assign heading   = heading_reg;

endmodule

>>> src/compass_heading.sv
// top level: pipelined cordic compass heading with declination correction
//
// Turns one signed magnetometer sample pair (mag_x, mag_y) into a heading in
// hundredths of a degree, measured from +X toward +Y, with the programmed
// declination added and one wrap into 0..36000. A sample transfer happens on
// every clock edge with start high; busy never rises, so a new pair may be
// presented every cycle. Each result appears on heading_centideg for exactly
// one cycle with done high, in input order, after one fold stage, one
// register per cordic micro-rotation, then multiply, round and
// declination/wrap stages. There is no back-pressure: the receiver must
// take each result in the cycle it is shown. Write decl_wdata with decl_we
// only while no sample is in flight; reset value is zero (magnetic heading).
module compass_heading #(
    parameter int SAMPLE_BITS   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] mag_x,
    input  logic signed [SAMPLE_BITS-1:0] mag_y,
    input  logic                          decl_we,
    input  chd_pkg::decl_t                decl_wdata,
    output logic                          done,
    output chd_pkg::centideg_t            heading_centideg
);
    import chd_pkg::*;

    // stages beyond the table length add nothing
    localparam int NUM_STAGES = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                : CORDIC_STAGES;

    decl_t  decl_reg;

    ctl_t   ctl_pipe [0:NUM_STAGES];
    vec_t   x_pipe   [0:NUM_STAGES];
    vec_t   y_pipe   [0:NUM_STAGES];
    angle_t z_pipe   [0:NUM_STAGES];

    // fully pipelined, never refuses a transfer
    assign busy = 1'b0;

    // declination register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= '0;
        end
        else if (decl_we)
        begin
            decl_reg <= decl_wdata;
        end
    end

    // fold into right half plane, flag y-zero cases
    chd_prerotate #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_prerotate (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .mag_x    (mag_x),
        .mag_y    (mag_y),
        .ctl_out  (ctl_pipe[0]),
        .x_out    (x_pipe[0]),
        .y_out    (y_pipe[0]),
        .z_out    (z_pipe[0])
    );

    // unrolled cordic: one register stage per micro-rotation
    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_cordic
        chd_cordic_stage #(
            .IDX (i)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_pipe[i]),
            .x_in    (x_pipe[i]),
            .y_in    (y_pipe[i]),
            .z_in    (z_pipe[i]),
            .ctl_out (ctl_pipe[i+1]),
            .x_out   (x_pipe[i+1]),
            .y_out   (y_pipe[i+1]),
            .z_out   (z_pipe[i+1])
        );
    end

    // x/y magnitudes of the last stage are not needed, only the angle
    chd_convert u_convert (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl_pipe[NUM_STAGES]),
        .z_in      (z_pipe[NUM_STAGES]),
        .decl      (decl_reg),
        .out_valid (done),
        .heading   (heading_centideg)
    );

endmodule

>>> src/chd_checker.sv
// port-level checker for the compass heading pipeline, bound to the top level
module chd_checker #(
    parameter int SAMPLE_BITS   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic signed [SAMPLE_BITS-1:0] mag_y,
    input logic                          done,
    input chd_pkg::centideg_t            heading_centideg
);
    import chd_pkg::*;

    localparam int NUM_STAGES = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                : CORDIC_STAGES;
    localparam int LATENCY    = PRE_LATENCY + NUM_STAGES + POST_LATENCY;

    // every accepted sample gives a result after the fixed latency
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("missing result after accepted sample");

    // no result without a sample accepted the fixed latency earlier
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching sample");

    // wrapped heading stays in range
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (heading_centideg <= FULL_CENTIDEG))
        else $error("heading out of range");

    // the pipeline takes a sample transfer while results are flowing
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && $past(done)) |-> !busy)
        else $error("busy while results flowing");

    // payload held while a y-zero sample is flagged does not matter, only
    // that a result follows even for the degenerate axis case
    a_yzero_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mag_y == '0)) |-> ##LATENCY done)
        else $error("missing result for y-zero sample");

endmodule

bind compass_heading chd_checker #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
) u_chd_checker (.*);

>>> tb/sv/tb_compass_heading.sv
// self-checking testbench for the compass heading pipeline: directed and random sample transfers
`timescale 1ns / 100ps

module tb_compass_heading;

    import chd_pkg::*;

    localparam int SAMPLE_BITS   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int TURN_ENTRIES  = 24;
    // fold + cordic stages + conversion/declination, plus some slack
    localparam int DRAIN_CYCLES  = 24 + 4 + 8;
    localparam int RAND_PER_SET  = 88;
    localparam int MAX_PRINTS    = 40;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // what the driver does with the head of the job queue
    typedef enum logic [1:0] {
        JOB_SAMPLE,   // one sample transfer
        JOB_DECL,     // declination write once the pipe is empty
        JOB_SETTLE    // hold off until every heading has come back
    } job_kind_t;

    typedef struct {
        job_kind_t kind;
        sample_t   x;
        sample_t   y;
        decl_t     decl;
        int        idle_pct;
    } job_t;

    typedef struct {
        sample_t   x;
        sample_t   y;
        centideg_t heading;
    } heading_exp_t;

    // atan(2^-i) in 2^-32 turn units, rounded to nearest
    localparam logic [31:0] TURN_ATAN [TURN_ENTRIES] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      start      = 1'b0;
    logic      busy;
    sample_t   mag_x      = '0;
    sample_t   mag_y      = '0;
    logic      decl_we    = 1'b0;
    decl_t     decl_wdata = '0;
    logic      done;
    centideg_t heading_centideg;

    job_t         job_q[$];
    heading_exp_t heading_q[$];
    decl_t        decl_now = '0;   // testbench copy of the declination register
    int           errors   = 0;

    compass_heading #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mag_x            (mag_x),
        .mag_y            (mag_y),
        .decl_we          (decl_we),
        .decl_wdata       (decl_wdata),
        .done             (done),
        .heading_centideg (heading_centideg)
    );

    always #1 clk = ~clk;

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
    end

    // expected heading: vectoring cordic on the scaled pair, round to centidegrees,
    // add declination and wrap once
    function automatic centideg_t heading_of(input sample_t mx, input sample_t my,
                                             input decl_t decl);
        longint          x;
        longint          y;
        longint          xs;
        longint          ys;
        longint          h;
        logic [31:0]     z;
        longint unsigned prod;
        z = '0;
        if (my == 0)
        begin
            h = (mx < 0) ? 18000 : 0;
        end
        else
        begin
            x = longint'(mx) * (longint'(1) <<< (56 - SAMPLE_BITS));
            y = longint'(my) * (longint'(1) <<< (56 - SAMPLE_BITS));
            // fold the left half plane onto the right one
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = 32'h8000_0000;
            end
            for (int i = 0; i < CORDIC_STAGES && i < TURN_ENTRIES; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + TURN_ATAN[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - TURN_ATAN[i];
                end
            end
            // turn fraction to centidegrees, round half up
            prod = {32'h0, z} * 64'd36000 + 64'h8000_0000;
            h    = longint'(prod >> 32);
        end
        h = h + longint'(decl);
        if (h < 0)
            h = h + 36000;
        else if (h > 36000)
            h = h - 36000;
        return centideg_t'(h);
    endfunction

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch: %s", msg);
    endtask

    // random axis value: full range most of the time, plus small, scaled-down, extreme and zero values
    function automatic sample_t pick_axis();
        sample_t v;
        case ($urandom_range(9))
            5:       v = sample_t'($urandom_range(6)) - sample_t'(3);
            6:
            begin
                case ($urandom_range(4))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7FFF;
                    2:       v = -16'sd1;
                    3:       v = 16'sd1;
                    default: v = '0;
                endcase
            end
            7:       v = '0;
            8:       v = sample_t'($urandom) >>> $urandom_range(15);
            default: v = sample_t'($urandom);
        endcase
        return v;
    endfunction

    function automatic job_t sample_job(input sample_t x, input sample_t y, input int idle);
        job_t j;
        j.kind     = JOB_SAMPLE;
        j.x        = x;
        j.y        = y;
        j.decl     = '0;
        j.idle_pct = idle;
        return j;
    endfunction

    function automatic job_t ctl_job(input job_kind_t kind, input decl_t decl);
        job_t j;
        j.kind     = kind;
        j.x        = '0;
        j.y        = '0;
        j.decl     = decl;
        j.idle_pct = 0;
        return j;
    endfunction

    // driver: presents at most one job per falling edge, holds a transfer while busy is up
    always @(negedge clk)
    begin : drive_jobs
        logic    nxt_start;
        logic    nxt_we;
        sample_t nxt_x;
        sample_t nxt_y;
        decl_t   nxt_decl;
        job_t    head;
        if (rst_n)
        begin
            nxt_start = 1'b0;
            nxt_we    = 1'b0;
            nxt_x     = mag_x;
            nxt_y     = mag_y;
            nxt_decl  = decl_wdata;
            if (start && busy)
            begin
                // transfer not taken yet, keep it on the ports
                nxt_start = 1'b1;
            end
            else if (job_q.size() > 0)
            begin
                head = job_q[0];
                case (head.kind)
                    JOB_SAMPLE:
                    begin
                        if ($urandom_range(99) >= head.idle_pct)
                        begin
                            void'(job_q.pop_front());
                            nxt_start = 1'b1;
                            nxt_x     = head.x;
                            nxt_y     = head.y;
                        end
                    end
                    JOB_DECL:
                    begin
                        // register only changes with nothing in flight
                        if (heading_q.size() == 0 && !start)
                        begin
                            void'(job_q.pop_front());
                            nxt_we   = 1'b1;
                            nxt_decl = head.decl;
                        end
                    end
                    default:
                    begin
                        if (heading_q.size() == 0 && !start)
                            void'(job_q.pop_front());
                    end
                endcase
            end
            start      <= nxt_start;
            decl_we    <= nxt_we;
            mag_x      <= nxt_x;
            mag_y      <= nxt_y;
            decl_wdata <= nxt_decl;
        end
    end

    // monitor: tracks the register, predicts on each accepted transfer,
    // checks each strobed heading against the oldest prediction
    always @(posedge clk)
    begin : watch_ports
        heading_exp_t e;
        if (rst_n)
        begin
            if (done)
            begin
                if (heading_q.size() == 0)
                begin
                    flag_mismatch($sformatf("heading %0d with none pending",
                                            heading_centideg));
                end
                else
                begin
                    e = heading_q.pop_front();
                    if (heading_centideg !== e.heading)
                        flag_mismatch($sformatf("x=%0d y=%0d heading %0d, want %0d",
                                                e.x, e.y, heading_centideg, e.heading));
                end
            end
            if (decl_we)
                decl_now = decl_wdata;
            if (start && !busy)
            begin
                e.x       = mag_x;
                e.y       = mag_y;
                e.heading = heading_of(mag_x, mag_y, decl_now);
                heading_q.push_back(e);
            end
        end
    end

    // stimulus and end of run
    initial
    begin : run_jobs
        // sender idle percent per phase; the receiver cannot stall, so the phases with zero idle run flat out
        int idle_plan [4] = '{0, 73, 0, 7};
        decl_t d;
        sample_t ax;
        sample_t ay;

        // directed: axes, extremes, quadrant diagonals, angle just below a full turn
        job_q.push_back(sample_job(16'sd0, 16'sd0, 0));
        job_q.push_back(sample_job(16'sd1, 16'sd0, 0));
        job_q.push_back(sample_job(-16'sd1, 16'sd0, 0));
        job_q.push_back(sample_job(16'sh7FFF, 16'sd0, 0));
        job_q.push_back(sample_job(16'sh8000, 16'sd0, 0));
        job_q.push_back(sample_job(16'sd0, 16'sd1, 0));
        job_q.push_back(sample_job(16'sd0, -16'sd1, 0));
        job_q.push_back(sample_job(16'sd0, 16'sh7FFF, 0));
        job_q.push_back(sample_job(16'sd0, 16'sh8000, 0));
        job_q.push_back(sample_job(16'sh7FFF, 16'sh7FFF, 0));
        job_q.push_back(sample_job(16'sh8000, 16'sh8000, 0));
        job_q.push_back(sample_job(16'sh7FFF, 16'sh8000, 0));
        job_q.push_back(sample_job(16'sh8000, 16'sh7FFF, 0));
        job_q.push_back(sample_job(16'sd1, 16'sd1, 0));
        job_q.push_back(sample_job(-16'sd1, 16'sd1, 0));
        job_q.push_back(sample_job(-16'sd1, -16'sd1, 0));
        job_q.push_back(sample_job(16'sd1, -16'sd1, 0));
        job_q.push_back(sample_job(16'sh7FFF, -16'sd1, 0));
        job_q.push_back(sample_job(16'sh8000, -16'sd1, 0));
        job_q.push_back(sample_job(16'sh8000, 16'sd1, 0));
        job_q.push_back(ctl_job(JOB_SETTLE, '0));

        // each set: new declination, a few wrap corner samples, then random pairs
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       d = -16'sd18000;
                1:       d = 16'sd18000;
                2:       d = 16'sh7FFF;
                3:       d = 16'sh8000;
                7:       d = '0;
                default: d = decl_t'(int'($urandom_range(36000)) - 18000);
            endcase
            job_q.push_back(ctl_job(JOB_DECL, d));
            job_q.push_back(sample_job(-16'sd1, 16'sd0, idle_plan[p % 4]));
            job_q.push_back(sample_job(16'sd1, 16'sd0, idle_plan[p % 4]));
            job_q.push_back(sample_job(16'sh7FFF, -16'sd1, idle_plan[p % 4]));
            for (int n = 0; n < RAND_PER_SET; n++)
            begin
                ax = pick_axis();
                ay = pick_axis();
                job_q.push_back(sample_job(ax, ay, idle_plan[p % 4]));
                // sender pause until the pipe has emptied
                if (n == RAND_PER_SET / 2)
                    job_q.push_back(ctl_job(JOB_SETTLE, '0));
            end
        end

        @(posedge rst_n);
        do
            @(posedge clk);
        while (job_q.size() != 0 || heading_q.size() != 0 || start);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (heading_q.size() != 0)
            flag_mismatch($sformatf("%0d headings never came", heading_q.size()));
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #200000;
        $display("simulation failed");
        $finish;
    end

endmodule
